// ----- src/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/plr_pkg.sv -----
`timescale 1ns / 1ps

package plr_pkg;

  localparam int WORD_W    = 16;
  localparam int LA_W      = 10;
  localparam int THR_W     = 8;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  localparam int DEF_MAX_LOOKAHEAD = 1023;

  localparam logic [WORD_W-1:0] FULL_SCALE  = 16'hFFFF;
  localparam logic [WORD_W-1:0] PERCENT_DIV = 16'd655;

  localparam logic [CFG_IDX_W-1:0] CFG_GEN_WORD_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_WORD_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_WORD_TWO  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_DIV_PCT,
    S_DIV_RNG,
    S_DIV_SCL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/plr_div.sv -----
`timescale 1ns / 1ps

module plr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  plr_pkg::div_req_t  req,
  output plr_pkg::div_rsp_t  rsp
);
  import plr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;
  logic [WORD_W-1:0]    den_r, den_nxt;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      diff;

  // one restoring step per cycle, quotient bits shift in from the bottom
  always_comb begin
    rem_sh   = {rem_r, quo_r[WORD_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_nxt = diff[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- src/prng_lookahead_roll.sv -----
`timescale 1ns / 1ps
// one generator step per cycle, then three divisions on the single shared divider
// (percent, range divisor, scaled value); only the percent division when range_max
// is 0
// requests: one at a time, next input taken the cycle after the result is registered
// reset: synchronous active-low rst_n clears control, generator words to zero

module prng_lookahead_roll #(
  parameter int MAX_LOOKAHEAD = plr_pkg::DEF_MAX_LOOKAHEAD
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [plr_pkg::LA_W-1:0]      in_lookahead,
  input  logic [plr_pkg::WORD_W-1:0]    in_range_max,
  input  logic [plr_pkg::THR_W-1:0]     in_threshold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [plr_pkg::WORD_W-1:0]    out_raw_value,
  output logic [plr_pkg::WORD_W-1:0]    out_scaled_value,
  output logic [plr_pkg::PCT_W-1:0]     out_percent_value,
  output logic                          out_roll_hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plr_pkg::WORD_W-1:0]    cfg_data
);
  import plr_pkg::*;

`include "assert_macros.svh"

  localparam int SW = $clog2(MAX_LOOKAHEAD + 2);

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] gw0_r, gw1_r, gw2_r;
  logic [WORD_W-1:0] w0_r, w1_r, w2_r;
  logic [WORD_W-1:0] w0_nxt, w1_nxt, w2_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic [SW-1:0]     la_sat;
  logic [WORD_W-1:0] range_r, range_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [WORD_W-1:0] scaled_r, scaled_nxt;
  logic [WORD_W-1:0] rn;
  logic [WORD_W-1:0] w2_shift;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [WORD_W-1:0] out_raw_r;
  logic [WORD_W-1:0] out_scaled_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic              out_hit_r;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  plr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw0_r <= '0;
      gw1_r <= '0;
      gw2_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GEN_WORD_ZERO: gw0_r <= cfg_data;
        CFG_GEN_WORD_ONE:  gw1_r <= cfg_data;
        CFG_GEN_WORD_TWO:  gw2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // generator step on the working copy
  always_comb begin
    w2_shift = {w2_r[WORD_W-2:0], w1_r[WORD_W-1]};
    rn       = ({w1_r[4:0], 11'd0} + {5'd0, w0_r[WORD_W-1:5]}) ^ w2_shift;
  end

  always_comb begin
    if (32'(in_lookahead) > MAX_LOOKAHEAD) begin
      la_sat = SW'(MAX_LOOKAHEAD);
    end else begin
      la_sat = SW'(in_lookahead);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt        = state_r;
    w0_nxt           = w0_r;
    w1_nxt           = w1_r;
    w2_nxt           = w2_r;
    steps_nxt        = steps_r;
    range_nxt        = range_r;
    thr_nxt          = thr_r;
    pct_nxt          = pct_r;
    scaled_nxt       = scaled_r;
    div_req.start    = 1'b0;
    div_req.dividend = w0_r;
    div_req.divisor  = PERCENT_DIV;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          w0_nxt    = gw0_r;
          w1_nxt    = gw1_r;
          w2_nxt    = gw2_r;
          steps_nxt = la_sat + 1'b1;
          range_nxt = in_range_max;
          thr_nxt   = in_threshold;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        w0_nxt    = rn;
        w1_nxt    = w0_r;
        w2_nxt    = w1_r;
        steps_nxt = steps_r - 1'b1;
        if (steps_r == SW'(1)) begin
          div_req.start    = 1'b1;
          div_req.dividend = rn;
          div_req.divisor  = PERCENT_DIV;
          state_nxt        = S_DIV_PCT;
        end
      end
      S_DIV_PCT: begin
        if (div_rsp.done) begin
          pct_nxt = div_rsp.quotient[PCT_W-1:0];
          if (range_r == '0) begin
            scaled_nxt = '0;
            state_nxt  = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = FULL_SCALE;
            div_req.divisor  = range_r;
            state_nxt        = S_DIV_RNG;
          end
        end
      end
      S_DIV_RNG: begin
        // divisor is at least 1 here since range_max is at most full scale
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = w0_r;
          div_req.divisor  = div_rsp.quotient;
          state_nxt        = S_DIV_SCL;
        end
      end
      S_DIV_SCL: begin
        if (div_rsp.done) begin
          scaled_nxt = div_rsp.quotient;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r     <= w0_nxt;
    w1_r     <= w1_nxt;
    w2_r     <= w2_nxt;
    range_r  <= range_nxt;
    thr_r    <= thr_nxt;
    pct_r    <= pct_nxt;
    scaled_r <= scaled_nxt;
    if (out_load) begin
      out_raw_r    <= w0_r;
      out_scaled_r <= scaled_r;
      out_pct_r    <= pct_r;
      out_hit_r    <= (thr_r > {1'b0, pct_r});
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_value     = out_raw_r;
  assign out_scaled_value  = out_scaled_r;
  assign out_percent_value = out_pct_r;
  assign out_roll_hit      = out_hit_r;

  `ASSERT_IMPLIES(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `ASSERT_IMPLIES(a_step_count, clk, rst_n, state_r == S_STEP, steps_r != '0, "step count ran out in step state")
  `ASSERT_NEXT(a_accept_steps, clk, rst_n, in_valid && !in_stall, state_r == S_STEP, "transfer did not start stepping")
  `ASSERT_IMPLIES(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE, "result shown without completion")

endmodule

// ----- tb/sv/prng_lookahead_roll_tb.sv -----
`timescale 1ns / 1ps

module prng_lookahead_roll_tb;
  import plr_pkg::*;

  localparam int                   RESET_CYCLES   = 10;
  localparam int                   CFG_SETTLE     = 4;
  localparam int                   DRAIN_CYCLES   = 1100;
  localparam int                   WATCHDOG_LIMIT = 20000;
  localparam int                   RANDOM_ROLLS   = 550;
  localparam int                   MAX_REPORTS    = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic {OP_ROLL, OP_WRITE} op_kind_t;

  typedef struct {
    op_kind_t             kind;
    logic                 wait_idle;
    int                   gap;
    logic [LA_W-1:0]      lookahead;
    logic [WORD_W-1:0]    range_max;
    logic [THR_W-1:0]     threshold;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
  } stim_op_t;

  typedef struct {
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] scaled;
    logic [PCT_W-1:0]  percent;
    logic              hit;
  } roll_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LA_W-1:0]      in_lookahead = '0;
  logic [WORD_W-1:0]    in_range_max = '0;
  logic [THR_W-1:0]     in_threshold = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_raw_value;
  logic [WORD_W-1:0]    out_scaled_value;
  logic [PCT_W-1:0]     out_percent_value;
  logic                 out_roll_hit;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  stim_op_t     pending_ops[$];
  roll_result_t peek_results_q[$];
  stim_op_t     cur_op;
  logic [WORD_W-1:0] gen_words[3] = '{default: '0};

  bit in_taken;
  bit cfg_taken;
  bit calm_sender;
  int gap_left;
  int stall_left;
  int calm_left;
  int stall_pick;
  int quiet_cycles;
  int idle_run;
  int rolls_built;
  int rolls_sent;
  int results_seen;
  int writes_done;
  int hits_seen;
  int zero_range_seen;
  int mismatches;

  prng_lookahead_roll DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_lookahead     (in_lookahead),
    .in_range_max     (in_range_max),
    .in_threshold     (in_threshold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_raw_value    (out_raw_value),
    .out_scaled_value (out_scaled_value),
    .out_percent_value(out_percent_value),
    .out_roll_hit     (out_roll_hit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // runs the generator on a copy of the configured words and scales the last output
  function automatic roll_result_t peek_roll(logic [LA_W-1:0] lookahead,
                                             logic [WORD_W-1:0] range_max,
                                             logic [THR_W-1:0] threshold);
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] rn;
    logic [WORD_W-1:0] shifted_w2;
    logic [WORD_W-1:0] quotient;
    roll_result_t      res;
    int                steps;
    w0 = gen_words[0];
    w1 = gen_words[1];
    w2 = gen_words[2];
    rn = '0;
    steps = (int'(lookahead) > DEF_MAX_LOOKAHEAD) ? DEF_MAX_LOOKAHEAD : int'(lookahead);
    for (int k = 0; k <= steps; k++) begin
      rn = {w1[4:0], 11'b0} + {5'b0, w0[15:5]};
      shifted_w2 = {w2[14:0], w1[15]};
      rn = rn ^ shifted_w2;
      w2 = w1;
      w1 = w0;
      w0 = rn;
    end
    res.raw = rn;
    res.scaled = '0;
    if (range_max != '0) begin
      quotient = FULL_SCALE / range_max;
      if (quotient != '0) res.scaled = rn / quotient;
    end
    quotient = rn / PERCENT_DIV;
    res.percent = quotient[PCT_W-1:0];
    res.hit = ({8'b0, threshold} > quotient);
    return res;
  endfunction

  function automatic void add_roll(logic [LA_W-1:0] lookahead, logic [WORD_W-1:0] range_max,
                                   logic [THR_W-1:0] threshold);
    stim_op_t op;
    int       r;
    r = $urandom_range(0, 99);
    op.kind = OP_ROLL;
    op.wait_idle = ($urandom_range(0, 99) < 6);
    if (calm_sender || r < 50) op.gap = 0;
    else if (r < 90) op.gap = $urandom_range(1, 4);
    else op.gap = $urandom_range(10, 80);
    op.lookahead = lookahead;
    op.range_max = range_max;
    op.threshold = threshold;
    op.index = '0;
    op.data = '0;
    pending_ops.push_back(op);
    rolls_built++;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] data);
    stim_op_t op;
    op.kind = OP_WRITE;
    op.wait_idle = 1'b1;
    op.gap = 0;
    op.lookahead = '0;
    op.range_max = '0;
    op.threshold = '0;
    op.index = index;
    op.data = data;
    pending_ops.push_back(op);
  endfunction

  // sender: one nonblocking update per signal per falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_taken) || (cfg_valid && !cfg_taken)) begin
        // hold the payload until the transfer happens
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        gap_left--;
      end else if (pending_ops.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending_ops[0].kind == OP_WRITE) begin
        in_valid <= 1'b0;
        if (peek_results_q.size() == 0 && quiet_cycles >= CFG_SETTLE) begin
          cur_op = pending_ops.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= cur_op.index;
          cfg_data <= cur_op.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end else if (pending_ops[0].wait_idle && peek_results_q.size() != 0) begin
        // hold off until everything outstanding has drained
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        cur_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        cfg_valid <= 1'b0;
        in_lookahead <= cur_op.lookahead;
        in_range_max <= cur_op.range_max;
        in_threshold <= cur_op.threshold;
        gap_left = cur_op.gap;
      end
    end
  end

  // receiver back-pressure: short bursts, the odd long stall, calm stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall <= 1'b0;
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else if (stall_pick < 93) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 60);
      end else begin
        out_stall <= 1'b0;
        calm_left = $urandom_range(50, 400);
      end
    end
  end

  always @(posedge clk) begin
    in_taken = in_valid && !in_stall;
    cfg_taken = cfg_valid && cfg_ready;
    if (rst_n) begin
      if (in_taken) begin
        peek_results_q.push_back(peek_roll(in_lookahead, in_range_max, in_threshold));
        rolls_sent++;
        if (in_range_max == '0) zero_range_seen++;
      end
      if (cfg_taken) begin
        writes_done++;
        case (cfg_index)
          CFG_GEN_WORD_ZERO: gen_words[0] = cfg_data;
          CFG_GEN_WORD_ONE:  gen_words[1] = cfg_data;
          CFG_GEN_WORD_TWO:  gen_words[2] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (peek_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transfer: raw %h scaled %h pct %0d hit %0b",
                     out_raw_value, out_scaled_value, out_percent_value, out_roll_hit);
        end else begin
          if (out_roll_hit) hits_seen++;
          if (out_raw_value !== peek_results_q[0].raw ||
              out_scaled_value !== peek_results_q[0].scaled ||
              out_percent_value !== peek_results_q[0].percent ||
              out_roll_hit !== peek_results_q[0].hit) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d wrong (exp/got): raw %h/%h scaled %h/%h pct %0d/%0d hit %0b/%0b",
                       results_seen, peek_results_q[0].raw, out_raw_value,
                       peek_results_q[0].scaled, out_scaled_value,
                       peek_results_q[0].percent, out_percent_value,
                       peek_results_q[0].hit, out_roll_hit);
          end
          void'(peek_results_q.pop_front());
        end
        idle_run = 0;
      end else if (in_taken || cfg_taken) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
      quiet_cycles = (peek_results_q.size() == 0) ? quiet_cycles + 1 : 0;
    end
  end

  initial begin
    @(posedge rst_n);
    while (idle_run < WATCHDOG_LIMIT) @(negedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int                phase_len;
    int                n_writes;
    int                r;
    logic [LA_W-1:0]   la;
    logic [WORD_W-1:0] rmax;
    logic [THR_W-1:0]  thr;
    logic [WORD_W-1:0] word;

    // generator words still at their reset value of zero
    calm_sender = 1'b1;
    add_roll(10'd0, 16'd0, 8'd0);
    add_roll(10'd1023, 16'hFFFF, 8'd255);

    add_write(CFG_GEN_WORD_ZERO, 16'hACE1);
    add_write(CFG_GEN_WORD_ONE, 16'h1D2B);
    add_write(CFG_GEN_WORD_TWO, 16'h8F05);
    add_write(CFG_UNUSED_IDX, 16'hFFFF);
    calm_sender = 1'b0;
    add_roll(10'd0, 16'd1, 8'd0);
    add_roll(10'd0, 16'hFFFF, 8'd255);
    add_roll(10'd1, 16'd0, 8'd100);
    add_roll(10'd1023, 16'h8000, 8'd101);
    add_roll(10'd2, 16'd2, 8'd1);
    add_roll(10'd5, 16'd655, 8'd50);
    add_roll(10'd3, 16'h7FFF, 8'd200);
    add_roll(10'd7, 16'd1, 8'd255);
    add_roll(10'd1022, 16'd300, 8'd100);
    add_roll(10'd512, 16'd3, 8'd99);

    // all ones, then a lone carry bit in word one
    add_write(CFG_GEN_WORD_ZERO, 16'hFFFF);
    add_write(CFG_GEN_WORD_ONE, 16'hFFFF);
    add_write(CFG_GEN_WORD_TWO, 16'hFFFF);
    add_roll(10'd0, 16'hFFFF, 8'd255);
    add_roll(10'd1023, 16'd1, 8'd0);
    add_roll(10'd17, 16'd0, 8'd100);
    add_write(CFG_GEN_WORD_ZERO, 16'h0000);
    add_write(CFG_GEN_WORD_ONE, 16'h8000);
    add_write(CFG_GEN_WORD_TWO, 16'h0000);
    add_roll(10'd0, 16'd100, 8'd1);
    add_roll(10'd4, 16'hFFFE, 8'd101);
    add_roll(10'd340, 16'd21845, 8'd128);

    while (rolls_built < RANDOM_ROLLS + 25) begin
      n_writes = $urandom_range(1, 4);
      for (int k = 0; k < n_writes; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) word = 16'h0000;
        else if (r < 30) word = 16'hFFFF;
        else word = 16'($urandom_range(0, 65535));
        add_write(CFG_IDX_W'($urandom_range(0, 3)), word);
      end
      calm_sender = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 40);
      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 75) la = 10'($urandom_range(0, 31));
        else if (r < 95) la = 10'($urandom_range(0, 1023));
        else la = 10'($urandom_range(1000, 1023));
        r = $urandom_range(0, 99);
        if (r < 10) rmax = 16'd0;
        else if (r < 30) rmax = 16'($urandom_range(1, 16));
        else if (r < 40) rmax = 16'($urandom_range(32768, 65535));
        else rmax = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 60) thr = 8'($urandom_range(0, 110));
        else thr = 8'($urandom_range(0, 255));
        add_roll(la, rmax, thr);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || cfg_valid || peek_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d lookahead rolls (%0d with zero range), %0d generator word writes",
             rolls_sent, zero_range_seen, writes_done);
    $display("checked %0d results, %0d roll hits, %0d mismatches, %0d still outstanding",
             results_seen, hits_seen, mismatches, peek_results_q.size());
    if (mismatches == 0 && peek_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/plr_pkg.sv
src/plr_div.sv
src/prng_lookahead_roll.sv
tb/sv/prng_lookahead_roll_tb.sv
